// ===== rtl/core/lirs_pkg.sv =====
// Shared constants and types for the linear interpolation resampler.
package lirs_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int PHASE_W     = FRAC_BITS + 5;
    localparam int STEP_W      = 21;
    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 16;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS);
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int PROD_W      = DIFF_W + FRAC_BITS + 1;
    localparam int SUM_W       = SAMPLE_W + 3;

    localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(60211);

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_EMPTY  = 1'b1;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [PHASE_W-1:0]  phase_t;

endpackage

// ===== rtl/core/lirs_if.sv =====
// Valid/ready channel interfaces for the resampler input and output.
interface lirs_in_if
    import lirs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                op;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

interface lirs_out_if
    import lirs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic               last;

    modport source (output valid, output level, output last, input ready);
    modport sink   (input valid, input level, input last, output ready);
endinterface

// ===== rtl/core/lirs_mix.sv =====
// Interpolation datapath: one registered signed multiply and an offset add.
module lirs_mix
    import lirs_pkg::*;
(
    input  logic                 clk,
    input  logic                 load,
    input  sample_t              older,
    input  sample_t              newer,
    input  logic [FRAC_BITS-1:0] frac,
    output logic [LEVEL_W-1:0]   level
);

    logic [SAMPLE_W-1:0]      uo;
    logic [SAMPLE_W-1:0]      un;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SAMPLE_W-1:0]      base_reg;
    logic signed [PROD_W-FRAC_BITS-1:0] shifted;
    logic signed [SUM_W-1:0]  sum;

    // Offset binary view of both samples; the mix is base + diff * frac.
    assign uo   = older ^ {1'b1, {(SAMPLE_W-1){1'b0}}};
    assign un   = newer ^ {1'b1, {(SAMPLE_W-1){1'b0}}};
    assign diff = $signed({1'b0, un}) - $signed({1'b0, uo});

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_W'(diff * $signed({1'b0, frac}));
            base_reg <= uo;
        end
    end

    assign shifted = prod_reg[PROD_W-1:FRAC_BITS];
    assign sum     = $signed({{(SUM_W-SAMPLE_W){1'b0}}, base_reg})
                   + SUM_W'(shifted);

    always_comb
    begin
        if (sum < 0)
            level = '0;
        else if (sum > $signed(SUM_W'({LEVEL_W{1'b1}})))
            level = '1;
        else
            level = sum[LEVEL_W-1:0];
    end

endmodule

// ===== rtl/core/linear_interp_resampler.sv =====
// Top level of the linear interpolation sample rate converter.
//
//  Channel   Role    Payload             Notes
//  in_ch     sink    op, sample          one source sample or an empty marker
//  out_ch    source  level, last         offset-binary sample, last of its item
//  cfg       write   cfg_we, cfg_wdata   phase_step, Q5.16 source advance
//
// An input transaction is taken only while the sequencer is idle. An item that
// emits results runs ST_MUL, ST_FORM and ST_HOLD for each of them, an item with
// no results visits ST_MUL only, and priming items leave the sequencer idle.
// Each result passes through the shared multiplier and one add stage, then
// waits in the output register for as long as the sink holds ready low.
// Reset clears the sample pair, the phase and the priming count, and loads
// the step register with its default.
module linear_interp_resampler
    import lirs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    lirs_in_if.sink           in_ch,
    lirs_out_if.source        out_ch,
    input  logic              cfg_we,
    input  logic [STEP_W-1:0] cfg_wdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_FORM, ST_HOLD} state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    sample_t             older_reg;
    sample_t             newer_reg;
    phase_t              phase_reg;
    logic [1:0]          prime_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                out_valid_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic                last_reg;

    sample_t             in_value;
    logic                in_fire;
    logic [PHASE_W:0]    phase_sum;
    phase_t              phase_next;
    logic [LEVEL_W-1:0]  mix_level;
    logic                mix_load;

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.level = level_reg;
    assign out_ch.last  = last_reg;

    // An empty marker repeats the newer held sample.
    assign in_value = (in_ch.op == OP_EMPTY) ? newer_reg : in_ch.sample;

    // Phase advance saturates at the top of the phase range.
    assign phase_sum  = {1'b0, phase_reg} + (PHASE_W+1)'(step_reg);
    assign phase_next = phase_sum[PHASE_W] ? '1 : phase_sum[PHASE_W-1:0];

    // The multiplier is loaded only when the phase is below one, so the
    // fraction bits are the whole phase there.
    assign mix_load = (state_reg == ST_MUL) && (phase_reg < PHASE_ONE);

    lirs_mix u_mix (
        .clk   (clk),
        .load  (mix_load),
        .older (older_reg),
        .newer (newer_reg),
        .frac  (phase_reg[FRAC_BITS-1:0]),
        .level (mix_level)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_RESET;
            older_reg     <= '0;
            newer_reg     <= '0;
            phase_reg     <= '0;
            prime_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                step_reg <= cfg_wdata;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (prime_reg == 2'd0)
                        begin
                            // The first priming item fills both samples.
                            older_reg <= in_value;
                            newer_reg <= in_value;
                            prime_reg <= 2'd1;
                        end
                        else if (prime_reg == 2'd1)
                        begin
                            newer_reg <= in_value;
                            prime_reg <= 2'd2;
                        end
                        else
                        begin
                            older_reg <= newer_reg;
                            newer_reg <= in_value;
                            if (phase_reg >= PHASE_ONE)
                                phase_reg <= phase_reg - PHASE_ONE;
                            cnt_reg   <= '0;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    // A phase still at one or more means this item emits no
                    // further result.
                    if (phase_reg < PHASE_ONE)
                        state_reg <= ST_FORM;
                    else
                        state_reg <= ST_IDLE;
                end
                ST_FORM:
                begin
                    level_reg     <= mix_level;
                    last_reg      <= (phase_next >= PHASE_ONE) ||
                                     (cnt_reg == CNT_W'(MAX_RESULTS - 1));
                    phase_reg     <= phase_next;
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (out_ch.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        cnt_reg       <= cnt_reg + CNT_W'(1);
                        state_reg     <= last_reg ? ST_IDLE : ST_MUL;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The input side is never open while a result waits in the output register.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid_reg && in_ch.ready))
        else $error("input ready while a result is pending");

    // The sixty-fourth result of an item is always marked as its last.
    a_cap_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (cnt_reg == CNT_W'(MAX_RESULTS - 1)) |-> last_reg)
        else $error("result cap reached without last");

    // After the last result is taken the block is ready for the next item.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && out_ch.last |=> in_ch.ready)
        else $error("block not idle after last result");

    // No result leaves before the sample pair is primed.
    a_primed: assert property (@(posedge clk) disable iff (!rst_n)
        (prime_reg != 2'd2) |-> !out_valid_reg)
        else $error("result emitted while priming");

endmodule
